>>> hw/rtl/mrph_pkg.sv
`default_nettype none

package mrph_pkg;

  // Digit ports on the block, fixed by the interface
  localparam int POSITIONS  = 6;
  localparam int COUNT_BITS = 3;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MODULUS  = 3'd0,
    REG_WEIGHT_1 = 3'd1,
    REG_WEIGHT_2 = 3'd2,
    REG_WEIGHT_3 = 3'd3,
    REG_WEIGHT_4 = 3'd4,
    REG_WEIGHT_5 = 3'd5
  } cfg_reg_t;

endpackage

`default_nettype wire

>>> hw/rtl/mixed_radix_prime_hash.sv
`default_nettype none

// Channel   Direction  Handshake            Word
// --------  ---------  -------------------  ----------------------------------------
// in_       in         start & !busy        in_digit_0..5, in_digit_count
// out_      out        out_valid (1 cycle)  out_bucket
// cfg_      in         cfg_we               cfg_index, cfg_wdata
//
// A word enters every cycle; busy stays low. The pipe is one multiply stage,
// two adder stages, one compare-subtract stage per bit of the exact sum, and
// the output register; the per-bit remainder stages make up most of it.
// Reset is synchronous, clears the valid bits and sets the modulus to two,
// weight 0 to one and the other weights to zero; the receiver cannot stall,
// so the pipe never holds.
module mixed_radix_prime_hash
  import mrph_pkg::*;
#(
  parameter int MAX_DIGITS   = 6,
  parameter int DIGIT_BITS   = 16,
  parameter int MODULUS_BITS = 24
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  output logic                    busy,
  input  wire  [DIGIT_BITS-1:0]   in_digit_0,
  input  wire  [DIGIT_BITS-1:0]   in_digit_1,
  input  wire  [DIGIT_BITS-1:0]   in_digit_2,
  input  wire  [DIGIT_BITS-1:0]   in_digit_3,
  input  wire  [DIGIT_BITS-1:0]   in_digit_4,
  input  wire  [DIGIT_BITS-1:0]   in_digit_5,
  input  wire  [COUNT_BITS-1:0]   in_digit_count,
  output logic                    out_valid,
  output logic [MODULUS_BITS-1:0] out_bucket,
  input  wire                     cfg_we,
  input  wire  [CFG_IDX_BITS-1:0] cfg_index,
  input  wire  [MODULUS_BITS-1:0] cfg_wdata
);

  localparam int PROD_W = DIGIT_BITS + MODULUS_BITS;
  localparam int SUM_W  = PROD_W + $clog2(MAX_DIGITS);
  localparam int NPAIR  = (MAX_DIGITS + 1) / 2;
  localparam int NLANE  = 2 * NPAIR;

  // configuration
  logic [MODULUS_BITS-1:0] hash_modulus_r, hash_modulus_nxt;
  logic [MODULUS_BITS-1:0] weight_r   [POSITIONS];
  logic [MODULUS_BITS-1:0] weight_nxt [POSITIONS];
  logic                    mod_lt2;

  logic [DIGIT_BITS-1:0] digit_w [POSITIONS];

  // stage 1: weighted lanes
  logic [PROD_W-1:0] prod_r   [NLANE];
  logic [PROD_W-1:0] prod_nxt [NLANE];
  logic              prod_vld_r;

  // stage 2: pair sums
  logic [SUM_W-1:0] pair_r   [NPAIR];
  logic [SUM_W-1:0] pair_nxt [NPAIR];
  logic             pair_vld_r;

  // stage 3: exact sum
  logic [SUM_W-1:0] tot_r, tot_nxt;
  logic             tot_vld_r;

  // remainder stages, one bit of the sum each
  logic [MODULUS_BITS-1:0] rem_r    [SUM_W];
  logic [MODULUS_BITS-1:0] rem_nxt  [SUM_W];
  logic [MODULUS_BITS-1:0] rem_in   [SUM_W];
  logic [SUM_W-1:0]        sum_fwd  [SUM_W];
  logic                    vld_fwd  [SUM_W];
  logic [SUM_W-1:0]        sum_r    [SUM_W-1];
  logic [SUM_W-1:0]        vld_r;

  logic                    out_valid_r;
  logic [MODULUS_BITS-1:0] out_bucket_r, out_bucket_nxt;

  assign busy = 1'b0;

  assign digit_w[0] = in_digit_0;
  assign digit_w[1] = in_digit_1;
  assign digit_w[2] = in_digit_2;
  assign digit_w[3] = in_digit_3;
  assign digit_w[4] = in_digit_4;
  assign digit_w[5] = in_digit_5;

  always_comb begin
    hash_modulus_nxt = hash_modulus_r;
    for (int i = 0; i < POSITIONS; i++) begin
      weight_nxt[i] = weight_r[i];
    end
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS:  hash_modulus_nxt = cfg_wdata;
        REG_WEIGHT_1: weight_nxt[1]    = cfg_wdata;
        REG_WEIGHT_2: weight_nxt[2]    = cfg_wdata;
        REG_WEIGHT_3: weight_nxt[3]    = cfg_wdata;
        REG_WEIGHT_4: weight_nxt[4]    = cfg_wdata;
        REG_WEIGHT_5: weight_nxt[5]    = cfg_wdata;
        default: ;
      endcase
    end
  end

  assign mod_lt2 = (hash_modulus_r < MODULUS_BITS'(2));

  // Drop lanes at or beyond digit_count; a count above the lane count keeps all.
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      if (i < MAX_DIGITS && in_digit_count > COUNT_BITS'(i)) begin
        prod_nxt[i] = PROD_W'(digit_w[i]) * PROD_W'(weight_r[i]);
      end else begin
        prod_nxt[i] = '0;
      end
    end
  end

  always_comb begin
    for (int p = 0; p < NPAIR; p++) begin
      pair_nxt[p] = SUM_W'(prod_r[2*p]) + SUM_W'(prod_r[2*p+1]);
    end
  end

  always_comb begin
    tot_nxt = '0;
    for (int p = 0; p < NPAIR; p++) begin
      tot_nxt = tot_nxt + pair_r[p];
    end
  end

  // Restoring remainder: shift in the next sum bit, subtract the modulus if it fits.
  for (genvar k = 0; k < SUM_W; k++) begin : g_rem
    logic [MODULUS_BITS:0] trial;

    if (k == 0) begin : g_first
      assign rem_in[k]  = '0;
      assign sum_fwd[k] = tot_r;
      assign vld_fwd[k] = tot_vld_r;
    end else begin : g_next
      assign rem_in[k]  = rem_r[k-1];
      assign sum_fwd[k] = sum_r[k-1];
      assign vld_fwd[k] = vld_r[k-1];
    end

    assign trial = {rem_in[k], sum_fwd[k][SUM_W-1-k]};

    always_comb begin
      if (trial >= {1'b0, hash_modulus_r}) begin
        rem_nxt[k] = MODULUS_BITS'(trial - {1'b0, hash_modulus_r});
      end else begin
        rem_nxt[k] = MODULUS_BITS'(trial);
      end
    end
  end

  assign out_bucket_nxt = mod_lt2 ? '0 : rem_r[SUM_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_modulus_r <= MODULUS_BITS'(2);
      weight_r[0]    <= MODULUS_BITS'(1);
      for (int i = 1; i < POSITIONS; i++) begin
        weight_r[i] <= '0;
      end
      prod_vld_r  <= 1'b0;
      pair_vld_r  <= 1'b0;
      tot_vld_r   <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hash_modulus_r <= hash_modulus_nxt;
      for (int i = 0; i < POSITIONS; i++) begin
        weight_r[i] <= weight_nxt[i];
      end
      prod_vld_r  <= start && !busy;
      pair_vld_r  <= prod_vld_r;
      tot_vld_r   <= pair_vld_r;
      for (int k = 0; k < SUM_W; k++) begin
        vld_r[k] <= vld_fwd[k];
      end
      out_valid_r <= vld_r[SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NLANE; i++) begin
      prod_r[i] <= prod_nxt[i];
    end
    for (int p = 0; p < NPAIR; p++) begin
      pair_r[p] <= pair_nxt[p];
    end
    tot_r <= tot_nxt;
    for (int k = 0; k < SUM_W; k++) begin
      rem_r[k] <= rem_nxt[k];
    end
    for (int k = 0; k < SUM_W - 1; k++) begin
      sum_r[k] <= sum_fwd[k];
    end
    out_bucket_r <= out_bucket_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_bucket = out_bucket_r;

  // A modulus below two forces a zero bucket.
  a_small_modulus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ($past(hash_modulus_r) < MODULUS_BITS'(2)) |-> out_bucket == '0)
    else $error("bucket not zero for modulus below two");

  // The top lane is dropped when the count does not reach it.
  a_lane_mask: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_digit_count) < COUNT_BITS'(MAX_DIGITS) |-> prod_r[MAX_DIGITS-1] == '0)
    else $error("lane beyond digit count contributes to the sum");

  // Remainder stays below the modulus at the last stage while the modulus is held.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SUM_W-1] && $stable(hash_modulus_r) && !mod_lt2 && !$past(cfg_we)
      && ($past(hash_modulus_r) >= MODULUS_BITS'(2))
      |-> rem_r[SUM_W-1] < hash_modulus_r || $past(cfg_we, 2))
    else $error("remainder not below modulus");

endmodule

`default_nettype wire
